FILE: src/dhfk_pkg.sv
package dhfk_pkg;

    localparam int JOINT_COUNT_DEF   = 7;
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int POS_FRAC_BITS_DEF = 16;
    localparam int ANGLE_MAX_BITS    = 24;
    localparam int CORDIC_ITERS      = 24;
    localparam int POINT_COUNT       = 9;
    localparam int ROT_W             = 32;
    localparam int PROD_W            = 34;
    localparam int POS_W             = 40;
    localparam int OUT_W             = 20;
    localparam logic signed [ROT_W-1:0] Q30_ONE = 32'sd1073741824;
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

    typedef enum logic [1:0] {
        ALPHA_ZERO,
        ALPHA_POS,
        ALPHA_NEG
    } t_alpha;

    function automatic logic signed [33:0] atan_phase(logic [4:0] i);
        logic signed [33:0] v;
        unique case (i)
            5'd0:    v = 34'sd536870912;
            5'd1:    v = 34'sd316933406;
            5'd2:    v = 34'sd167458907;
            5'd3:    v = 34'sd85004756;
            5'd4:    v = 34'sd42667331;
            5'd5:    v = 34'sd21354465;
            5'd6:    v = 34'sd10679838;
            5'd7:    v = 34'sd5340245;
            5'd8:    v = 34'sd2670163;
            5'd9:    v = 34'sd1335087;
            5'd10:   v = 34'sd667544;
            5'd11:   v = 34'sd333772;
            5'd12:   v = 34'sd166886;
            5'd13:   v = 34'sd83443;
            5'd14:   v = 34'sd41722;
            5'd15:   v = 34'sd20861;
            5'd16:   v = 34'sd10430;
            5'd17:   v = 34'sd5215;
            5'd18:   v = 34'sd2608;
            5'd19:   v = 34'sd1304;
            5'd20:   v = 34'sd652;
            5'd21:   v = 34'sd326;
            5'd22:   v = 34'sd163;
            5'd23:   v = 34'sd81;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    function automatic t_alpha link_alpha(logic [2:0] k);
        t_alpha a;
        unique case (k)
            3'd1, 3'd4:       a = ALPHA_NEG;
            3'd2, 3'd3, 3'd5,
            3'd6:             a = ALPHA_POS;
            default:          a = ALPHA_ZERO;
        endcase
        return a;
    endfunction

    function automatic longint um_to_fixed(longint um, int frac);
        longint m;
        longint r;
        m = (um < 0) ? -um : um;
        r = (m * (64'sd1 <<< frac) + 64'sd500000) / 64'sd1000000;
        return (um < 0) ? -r : r;
    endfunction

endpackage

FILE: src/dhfk_mac.sv
module dhfk_mac
    import dhfk_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [ROT_W-1:0]  i_a,
    input  logic signed [ROT_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [63:0] prod;
    logic signed [63:0] rnd;
    logic signed [PROD_W-1:0] r_p;

    assign prod = 64'(i_a) * 64'(i_b);
    assign rnd  = prod + 64'sd536870912;

    always_ff @(posedge i_clk) begin
        r_p <= rnd[63:30];
    end

    assign o_p = r_p;

endmodule

FILE: src/dhfk_cordic.sv
module dhfk_cordic
    import dhfk_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [ANGLE_BITS-1:0]   i_angle,
    output logic                    o_done,
    output logic signed [ROT_W-1:0] o_cos,
    output logic signed [ROT_W-1:0] o_sin
);

    logic [31:0]        ph;
    logic               flip;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [33:0] r_z;
    logic               r_flip;
    logic [4:0]         r_iter;
    logic               r_busy;
    logic               r_done;

    assign ph   = {i_angle, {(32 - ANGLE_BITS){1'b0}}};
    assign flip = ph[31] ^ ph[30];
    assign dx   = r_y >>> r_iter;
    assign dy   = r_x >>> r_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_iter == 5'(CORDIC_ITERS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
                r_flip <= flip;
                r_x    <= CORDIC_START;
                r_y    <= '0;
                r_z    <= 34'($signed({ph[31] ^ flip, ph[30:0]}));
            end else if (r_busy) begin
                if (r_z >= 0) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - atan_phase(r_iter);
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + atan_phase(r_iter);
                end
                if (r_iter == 5'(CORDIC_ITERS - 1)) begin
                    r_busy <= 1'b0;
                end else begin
                    r_iter <= r_iter + 5'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_flip ? -r_x[ROT_W-1:0] : r_x[ROT_W-1:0];
    assign o_sin  = r_flip ? -r_y[ROT_W-1:0] : r_y[ROT_W-1:0];

endmodule

FILE: src/dh_forward_kinematics_7dof.sv
// seven-joint forward kinematics, modified dh links
// input channel: one beat carries seven joint angles (i_valid / o_stall);
// o_stall is high from the accepted beat until the ninth origin is loaded
// into the output register
// output channel: nine beats per pose (o_valid / i_stall): base, joints 1-7,
// flange; o_last_point marks the flange beat
// each link loads its rotated basis, runs a 24-step cordic for the joint angle
// (skipped for the flange link), then issues 18 products through one shared
// 32x32 multiplier (6 for the flange link), then a flush and an output load
// the pose time is set by the cordic iterations and the single multiplier; the
// next pose is accepted only once the flange beat is loaded and the sequencer
// is back in idle
// a stalled output holds its beat and the sequencer waits before the next load
// reset empties the output register and returns the sequencer to idle
module dh_forward_kinematics_7dof
    import dhfk_pkg::*;
#(
    parameter int JOINT_COUNT   = JOINT_COUNT_DEF,
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [15:0]      i_joint_angle_1,
    input  logic signed [15:0]      i_joint_angle_2,
    input  logic signed [15:0]      i_joint_angle_3,
    input  logic signed [15:0]      i_joint_angle_4,
    input  logic signed [15:0]      i_joint_angle_5,
    input  logic signed [15:0]      i_joint_angle_6,
    input  logic signed [15:0]      i_joint_angle_7,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [3:0]              o_point_index,
    output logic signed [OUT_W-1:0] o_pos_x,
    output logic signed [OUT_W-1:0] o_pos_y,
    output logic signed [OUT_W-1:0] o_pos_z,
    output logic                    o_last_point
);

    localparam longint A3 = um_to_fixed(64'sd82500, POS_FRAC_BITS);
    localparam longint A4 = um_to_fixed(-64'sd82500, POS_FRAC_BITS);
    localparam longint A6 = um_to_fixed(64'sd88000, POS_FRAC_BITS);
    localparam longint D0 = um_to_fixed(64'sd333000, POS_FRAC_BITS);
    localparam longint D2 = um_to_fixed(64'sd316000, POS_FRAC_BITS);
    localparam longint D4 = um_to_fixed(64'sd384000, POS_FRAC_BITS);
    localparam longint D7 = um_to_fixed(64'sd107000, POS_FRAC_BITS);
    localparam logic [2:0] LAST_LINK = 3'(JOINT_COUNT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_LATCH,
        S_CORD,
        S_MULT,
        S_FLUSH
    } t_state;

    t_state r_state;
    logic [2:0] r_link;
    logic [3:0] r_pidx;
    logic [4:0] r_op;
    logic [4:0] r_pop;
    logic       r_pv;
    logic [15:0] r_ang [JOINT_COUNT];
    logic signed [ROT_W-1:0] r_rot [3][3];
    logic signed [ROT_W-1:0] r_m [3][3];
    logic signed [POS_W-1:0] r_pos [3];
    logic       r_ov;
    logic [3:0] r_oidx;
    logic signed [OUT_W-1:0] r_ox;
    logic signed [OUT_W-1:0] r_oy;
    logic signed [OUT_W-1:0] r_oz;
    logic       r_olast;

    logic [ANGLE_MAX_BITS-1:0] ang_ext;
    logic cord_start;
    logic cord_done;
    logic signed [ROT_W-1:0] cos_v;
    logic signed [ROT_W-1:0] sin_v;
    logic signed [ROT_W-1:0] mul_a;
    logic signed [ROT_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [POS_W-1:0] prod_ext;
    logic [4:0] iss_t;
    logic [4:0] acc_t;
    logic [1:0] iss_row;
    logic [1:0] acc_row;
    logic signed [ROT_W-1:0] len_a;
    logic signed [ROT_W-1:0] len_d;
    t_alpha alpha;

    function automatic logic signed [OUT_W-1:0] sat(logic signed [POS_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > 40'sd524287) begin
            r = 20'sd524287;
        end else if (v < -40'sd524288) begin
            r = -20'sd524288;
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    assign ang_ext    = {{(ANGLE_MAX_BITS - 16){1'b0}}, r_ang[r_link]};
    assign cord_start = (r_state == S_LATCH) && (r_link != LAST_LINK);
    assign alpha      = link_alpha(r_link);

    always_comb begin
        len_a = '0;
        len_d = '0;
        unique case (r_link)
            3'd0:    len_d = 32'(D0);
            3'd2:    len_d = 32'(D2);
            3'd3:    len_a = 32'(A3);
            3'd4:    begin
                len_a = 32'(A4);
                len_d = 32'(D4);
            end
            3'd6:    len_a = 32'(A6);
            3'd7:    len_d = 32'(D7);
            default: len_a = '0;
        endcase
    end

    dhfk_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_angle (ang_ext[ANGLE_BITS-1:0]),
        .o_done  (cord_done),
        .o_cos   (cos_v),
        .o_sin   (sin_v)
    );

    assign iss_t   = r_op - 5'd6;
    assign iss_row = (r_op < 5'd6) ? r_op[2:1] : iss_t[3:2];

    always_comb begin
        if (r_op < 5'd6) begin
            mul_a = r_op[0] ? r_m[iss_row][2] : r_m[iss_row][0];
            mul_b = r_op[0] ? len_d : len_a;
        end else begin
            unique case (iss_t[1:0])
                2'd0: begin
                    mul_a = r_m[iss_row][0];
                    mul_b = cos_v;
                end
                2'd1: begin
                    mul_a = r_m[iss_row][1];
                    mul_b = sin_v;
                end
                2'd2: begin
                    mul_a = r_m[iss_row][1];
                    mul_b = cos_v;
                end
                default: begin
                    mul_a = r_m[iss_row][0];
                    mul_b = sin_v;
                end
            endcase
        end
    end

    dhfk_mac u_mac (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign prod_ext = POS_W'(prod);
    assign acc_t    = r_pop - 5'd6;
    assign acc_row  = (r_pop < 5'd6) ? r_pop[2:1] : acc_t[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
            r_link  <= '0;
            r_pidx  <= '0;
            r_op    <= '0;
        end else begin
            if (!i_stall && (r_state != S_EMIT)) begin
                r_ov <= 1'b0;
            end
            if (r_pv) begin
                if (r_pop < 5'd6) begin
                    r_pos[acc_row] <= r_pos[acc_row] + prod_ext;
                end else begin
                    unique case (acc_t[1:0])
                        2'd0: r_rot[acc_row][0] <= prod[ROT_W-1:0];
                        2'd1: r_rot[acc_row][0] <= r_rot[acc_row][0] + prod[ROT_W-1:0];
                        2'd2: r_rot[acc_row][1] <= prod[ROT_W-1:0];
                        default: r_rot[acc_row][1] <= r_rot[acc_row][1] - prod[ROT_W-1:0];
                    endcase
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_ang[0] <= i_joint_angle_1;
                        r_ang[1] <= i_joint_angle_2;
                        r_ang[2] <= i_joint_angle_3;
                        r_ang[3] <= i_joint_angle_4;
                        r_ang[4] <= i_joint_angle_5;
                        r_ang[5] <= i_joint_angle_6;
                        r_ang[6] <= i_joint_angle_7;
                        for (int r = 0; r < 3; r++) begin
                            r_pos[r] <= '0;
                            for (int c = 0; c < 3; c++) begin
                                r_rot[r][c] <= (r == c) ? Q30_ONE : '0;
                            end
                        end
                        r_link  <= '0;
                        r_pidx  <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_ov || !i_stall) begin
                        r_ov    <= 1'b1;
                        r_oidx  <= r_pidx;
                        r_ox    <= sat(r_pos[0]);
                        r_oy    <= sat(r_pos[1]);
                        r_oz    <= sat(r_pos[2]);
                        r_olast <= (r_pidx == 4'(POINT_COUNT - 1));
                        r_state <= (r_pidx == 4'(POINT_COUNT - 1)) ? S_IDLE : S_LATCH;
                    end
                end
                S_LATCH: begin
                    for (int r = 0; r < 3; r++) begin
                        r_m[r][0] <= r_rot[r][0];
                        unique case (alpha)
                            ALPHA_POS: begin
                                r_m[r][1] <= r_rot[r][2];
                                r_m[r][2] <= -r_rot[r][1];
                            end
                            ALPHA_NEG: begin
                                r_m[r][1] <= -r_rot[r][2];
                                r_m[r][2] <= r_rot[r][1];
                            end
                            default: begin
                                r_m[r][1] <= r_rot[r][1];
                                r_m[r][2] <= r_rot[r][2];
                            end
                        endcase
                    end
                    r_op    <= '0;
                    r_state <= (r_link == LAST_LINK) ? S_MULT : S_CORD;
                end
                S_CORD: begin
                    if (cord_done) begin
                        r_state <= S_MULT;
                    end
                end
                S_MULT: begin
                    r_pv  <= 1'b1;
                    r_pop <= r_op;
                    if (r_op == ((r_link == LAST_LINK) ? 5'd5 : 5'd17)) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_op <= r_op + 5'd1;
                    end
                end
                default: begin
                    r_pv <= 1'b0;
                    for (int r = 0; r < 3; r++) begin
                        r_rot[r][2] <= r_m[r][2];
                    end
                    r_pidx  <= 4'(r_link) + 4'd1;
                    r_link  <= r_link + 3'd1;
                    r_state <= S_EMIT;
                end
            endcase
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_ov;
    assign o_point_index = r_oidx;
    assign o_pos_x       = r_ox;
    assign o_pos_y       = r_oy;
    assign o_pos_z       = r_oz;
    assign o_last_point  = r_olast;

endmodule
